// ===== rtl/pfc_lru_pkg.sv =====
package pfc_lru_pkg;

  localparam int TAG_W = 224;
  localparam int REF_W = 16;
  localparam logic [REF_W-1:0] REF_MAX = '1;

  localparam logic [3:0] ST_HIT      = 4'd0;
  localparam logic [3:0] ST_NEW      = 4'd1;
  localparam logic [3:0] ST_RECYCLED = 4'd2;
  localparam logic [3:0] ST_MISS     = 4'd3;
  localparam logic [3:0] ST_NONE     = 4'd4;
  localparam logic [3:0] ST_RELEASED = 4'd5;
  localparam logic [3:0] ST_UNPINNED = 4'd6;
  localparam logic [3:0] ST_BAD_REL  = 4'd7;
  localparam logic [3:0] ST_OVERFLOW = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MISS,
    S_HIT,
    S_REL,
    S_PUSH1,
    S_PUSH2,
    S_UNLINK
  } state_t;

endpackage

// ===== rtl/page_frame_cache_lru.sv =====
// Page frame cache with LRU recycling.
// Command channel: a word is taken when start is high and busy is low. op 0
// fetches by key (file_id_* and page_number), op 1 releases frame_to_release.
// Result channel: one word per command, shown for one cycle with done high;
// the receiver cannot stall, so the result is simply dropped onto the ports.
// Steps:
//   release          a bad index or invalid frame is refused from idle; else
//                    the count is read and dropped, and when it reaches zero
//                    the frame is pushed on at the head of the LRU list
//   fetch            scans the V valid frames through the tag memory at one
//                    entry a cycle (none when no frame is valid); a hit ends
//                    the scan early; an unpinned hit or a recycle unlinks it
// The tag scan through the single read port of the tag memory sets the rate.
// Valid frames are those at or above the fill count (frames are handed out
// from the top down), and a valid frame is on the LRU list exactly when its
// count is zero, so no per-frame flags are kept. Reset empties the list
// (anchor head and tail point to the anchor) and sets the fill count to
// FRAMES; no clearing pass is needed, busy is low the cycle after reset.
module page_frame_cache_lru #(
  parameter int FRAMES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic        alloc_new,
  input  logic [63:0] file_id_high,
  input  logic [63:0] file_id_middle,
  input  logic [63:0] file_id_low,
  input  logic [31:0] page_number,
  input  logic [5:0]  frame_to_release,
  output logic        done,
  output logic [3:0]  status,
  output logic [5:0]  frame_index,
  output logic [15:0] reference_count
);

  localparam int IW = $clog2(FRAMES);   // frame index
  localparam int CW = IW + 1;           // counts up to FRAMES
  localparam int NW = $clog2(FRAMES + 1); // link, anchor = FRAMES
  localparam logic [NW-1:0] ANCHOR = NW'(FRAMES);
  localparam logic [CW-1:0] FULL = CW'(FRAMES);

  localparam int TW = pfc_lru_pkg::TAG_W;
  localparam int RW = pfc_lru_pkg::REF_W;

  // memories
  logic [TW-1:0] tag_mem  [FRAMES];
  logic [RW-1:0] refs_mem [FRAMES];
  logic [NW-1:0] next_mem [FRAMES];
  logic [NW-1:0] prev_mem [FRAMES];
  logic [TW-1:0] tag_q;
  logic [RW-1:0] refs_q;
  logic [NW-1:0] next_q, prev_q;

  // control and payload registers
  pfc_lru_pkg::state_t state, state_next;
  logic [CW-1:0] unused, unused_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          pv, pv_next;
  logic [IW-1:0] pidx, pidx_next;
  logic [IW-1:0] idx, idx_next;
  logic [NW-1:0] head, head_next, tail, tail_next;
  logic [NW-1:0] old_head, old_head_next;
  logic [TW-1:0] key, key_next;
  logic          alloc, alloc_next;
  logic          recycle, recycle_next;
  logic [RW-1:0] refs_r, refs_r_next;
  logic          done_next;
  logic [3:0]    status_next;
  logic [5:0]    frame_index_next;
  logic [15:0]   reference_count_next;

  // memory ports
  logic [IW-1:0] rd_addr;
  logic          tag_we, refs_we, next_we, prev_we;
  logic [IW-1:0] tag_wa, refs_wa, next_wa, prev_wa;
  logic [RW-1:0] refs_wd;
  logic [NW-1:0] next_wd, prev_wd;

  logic accept, rel_bad_idx, match;

  assign busy   = (state != pfc_lru_pkg::S_IDLE);
  assign accept = start && !busy;
  assign match  = pv && (tag_q == key);
  // out of range, or below the fill count so never handed out
  assign rel_bad_idx = (int'(frame_to_release) >= FRAMES) ||
                       (int'(frame_to_release) < int'(unused));

  always_ff @(posedge clk) begin
    tag_q  <= tag_mem[rd_addr];
    refs_q <= refs_mem[rd_addr];
    next_q <= next_mem[rd_addr];
    prev_q <= prev_mem[rd_addr];
    if (tag_we) tag_mem[tag_wa] <= key;
    if (refs_we) refs_mem[refs_wa] <= refs_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pfc_lru_pkg::S_IDLE: begin
        if (accept) begin
          if (op) begin
            if (!rel_bad_idx) state_next = pfc_lru_pkg::S_REL;
          end else if (unused == FULL) begin
            state_next = pfc_lru_pkg::S_MISS;
          end else begin
            state_next = pfc_lru_pkg::S_SCAN;
          end
        end
      end
      pfc_lru_pkg::S_SCAN: begin
        if (match) state_next = pfc_lru_pkg::S_HIT;
        else if (cnt == FULL) state_next = pfc_lru_pkg::S_MISS;
      end
      pfc_lru_pkg::S_MISS: begin
        if (alloc && unused == '0 && tail != ANCHOR) state_next = pfc_lru_pkg::S_UNLINK;
        else state_next = pfc_lru_pkg::S_IDLE;
      end
      pfc_lru_pkg::S_HIT: begin
        if (refs_r == '0) state_next = pfc_lru_pkg::S_UNLINK;
        else state_next = pfc_lru_pkg::S_IDLE;
      end
      pfc_lru_pkg::S_REL: begin
        if (refs_q == RW'(1)) state_next = pfc_lru_pkg::S_PUSH1;
        else state_next = pfc_lru_pkg::S_IDLE;
      end
      pfc_lru_pkg::S_PUSH1:  state_next = pfc_lru_pkg::S_PUSH2;
      pfc_lru_pkg::S_PUSH2:  state_next = pfc_lru_pkg::S_IDLE;
      pfc_lru_pkg::S_UNLINK: state_next = pfc_lru_pkg::S_IDLE;
      default:               state_next = pfc_lru_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    unused_next   = unused;
    cnt_next      = cnt;
    pv_next       = 1'b0;
    pidx_next     = pidx;
    idx_next      = idx;
    head_next     = head;
    tail_next     = tail;
    old_head_next = old_head;
    key_next      = key;
    alloc_next    = alloc;
    recycle_next  = recycle;
    refs_r_next   = refs_r;
    done_next            = 1'b0;
    status_next          = status;
    frame_index_next     = frame_index;
    reference_count_next = reference_count;
    rd_addr = idx;
    tag_we  = 1'b0;
    refs_we = 1'b0;
    next_we = 1'b0;
    prev_we = 1'b0;
    tag_wa  = idx;
    refs_wa = idx;
    next_wa = idx;
    prev_wa = idx;
    refs_wd = '0;
    next_wd = '0;
    prev_wd = '0;
    case (state)
      pfc_lru_pkg::S_IDLE: begin
        if (accept) begin
          key_next   = {file_id_high, file_id_middle, file_id_low, page_number};
          alloc_next = alloc_new;
          cnt_next   = unused;
          idx_next   = IW'(frame_to_release);
          rd_addr    = IW'(frame_to_release);
          if (op && rel_bad_idx) begin
            done_next            = 1'b1;
            status_next          = pfc_lru_pkg::ST_BAD_REL;
            frame_index_next     = frame_to_release;
            reference_count_next = '0;
          end
        end
      end
      pfc_lru_pkg::S_SCAN: begin
        // one read a cycle, compared in the next cycle
        rd_addr = cnt[IW-1:0];
        if (cnt != FULL) begin
          pv_next   = 1'b1;
          pidx_next = cnt[IW-1:0];
          cnt_next  = cnt + CW'(1);
        end
        if (match) begin
          idx_next    = pidx;
          refs_r_next = refs_q;
        end
      end
      pfc_lru_pkg::S_HIT: begin
        rd_addr = idx;
        if (refs_r == pfc_lru_pkg::REF_MAX) begin
          done_next            = 1'b1;
          status_next          = pfc_lru_pkg::ST_OVERFLOW;
          frame_index_next     = 6'(idx);
          reference_count_next = pfc_lru_pkg::REF_MAX;
        end else begin
          refs_we = 1'b1;
          refs_wd = refs_r + RW'(1);
          recycle_next = 1'b0;
          if (refs_r != '0) begin
            done_next            = 1'b1;
            status_next          = pfc_lru_pkg::ST_HIT;
            frame_index_next     = 6'(idx);
            reference_count_next = refs_r + RW'(1);
          end
        end
      end
      pfc_lru_pkg::S_MISS: begin
        rd_addr = tail[IW-1:0];
        done_next            = 1'b1;
        frame_index_next     = '0;
        reference_count_next = '0;
        if (!alloc) begin
          status_next = pfc_lru_pkg::ST_MISS;
        end else if (unused != '0) begin
          unused_next = unused - CW'(1);
          tag_we  = 1'b1;
          tag_wa  = unused_next[IW-1:0];
          refs_we = 1'b1;
          refs_wa = unused_next[IW-1:0];
          refs_wd = RW'(1);
          status_next          = pfc_lru_pkg::ST_NEW;
          frame_index_next     = 6'(unused_next[IW-1:0]);
          reference_count_next = 16'd1;
        end else if (tail != ANCHOR) begin
          done_next    = 1'b0;
          idx_next     = tail[IW-1:0];
          recycle_next = 1'b1;
          tag_we  = 1'b1;
          tag_wa  = tail[IW-1:0];
          refs_we = 1'b1;
          refs_wa = tail[IW-1:0];
          refs_wd = RW'(1);
        end else begin
          status_next = pfc_lru_pkg::ST_NONE;
        end
      end
      pfc_lru_pkg::S_UNLINK: begin
        // next[prev] = next, prev[next] = prev
        if (prev_q == ANCHOR) begin
          head_next = next_q;
        end else begin
          next_we = 1'b1;
          next_wa = prev_q[IW-1:0];
          next_wd = next_q;
        end
        if (next_q == ANCHOR) begin
          tail_next = prev_q;
        end else begin
          prev_we = 1'b1;
          prev_wa = next_q[IW-1:0];
          prev_wd = prev_q;
        end
        done_next            = 1'b1;
        status_next          = recycle ? pfc_lru_pkg::ST_RECYCLED : pfc_lru_pkg::ST_HIT;
        frame_index_next     = 6'(idx);
        reference_count_next = 16'd1;
      end
      pfc_lru_pkg::S_REL: begin
        if (refs_q == '0) begin
          done_next            = 1'b1;
          status_next          = pfc_lru_pkg::ST_BAD_REL;
          frame_index_next     = 6'(idx);
          reference_count_next = '0;
        end else begin
          refs_we = 1'b1;
          refs_wd = refs_q - RW'(1);
          if (refs_q != RW'(1)) begin
            done_next            = 1'b1;
            status_next          = pfc_lru_pkg::ST_RELEASED;
            frame_index_next     = 6'(idx);
            reference_count_next = refs_q - RW'(1);
          end
        end
      end
      pfc_lru_pkg::S_PUSH1: begin
        next_we = 1'b1;
        next_wd = head;
        prev_we = 1'b1;
        prev_wd = ANCHOR;
        old_head_next = head;
        head_next     = NW'(idx);
      end
      pfc_lru_pkg::S_PUSH2: begin
        if (old_head == ANCHOR) begin
          tail_next = NW'(idx);
        end else begin
          prev_we = 1'b1;
          prev_wa = old_head[IW-1:0];
          prev_wd = NW'(idx);
        end
        done_next            = 1'b1;
        status_next          = pfc_lru_pkg::ST_UNPINNED;
        frame_index_next     = 6'(idx);
        reference_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pfc_lru_pkg::S_IDLE;
      unused <= FULL;
      head   <= ANCHOR;
      tail   <= ANCHOR;
      pv     <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      unused <= unused_next;
      head   <= head_next;
      tail   <= tail_next;
      pv     <= pv_next;
      done   <= done_next;
    end
    cnt             <= cnt_next;
    pidx            <= pidx_next;
    idx             <= idx_next;
    old_head        <= old_head_next;
    key             <= key_next;
    alloc           <= alloc_next;
    recycle         <= recycle_next;
    refs_r          <= refs_r_next;
    status          <= status_next;
    frame_index     <= frame_index_next;
    reference_count <= reference_count_next;
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) unused <= FULL)
    else $error("fill count beyond frame count");
  a_one_per_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(accept))
    else $error("result without a command");
  a_no_frame: assert property (@(posedge clk) disable iff (rst)
    done && (status == pfc_lru_pkg::ST_MISS || status == pfc_lru_pkg::ST_NONE)
    |-> frame_index == '0 && reference_count == '0)
    else $error("frame reported on a miss");
  a_new_one: assert property (@(posedge clk) disable iff (rst)
    done && (status == pfc_lru_pkg::ST_NEW || status == pfc_lru_pkg::ST_RECYCLED)
    |-> reference_count == 16'd1)
    else $error("fresh frame count not one");
  a_list_ends: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (head == ANCHOR) == (tail == ANCHOR))
    else $error("LRU head and tail disagree on empty list");
`endif

endmodule
